@@ rtl/iffp_pkg.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// iffp_pkg: shared types and constants of the flow header parser
// Field positions, header constants and the record handed from the
// capture front end to the verdict back end.
// ----------------------------------------------------------------------------
package iffp_pkg;

  localparam int unsigned CountW = 17;
  localparam logic [CountW-1:0] COUNT_MAX = '1;

  // byte positions within the frame
  localparam logic [CountW-1:0] POS_ETYPE_HI = 17'd12;
  localparam logic [CountW-1:0] POS_ETYPE_LO = 17'd13;
  localparam logic [CountW-1:0] POS_VER_IHL  = 17'd14;
  localparam logic [CountW-1:0] POS_TLEN_HI  = 17'd16;
  localparam logic [CountW-1:0] POS_TLEN_LO  = 17'd17;
  localparam logic [CountW-1:0] POS_FRAG_HI  = 17'd20;
  localparam logic [CountW-1:0] POS_FRAG_LO  = 17'd21;
  localparam logic [CountW-1:0] POS_TTL      = 17'd22;
  localparam logic [CountW-1:0] POS_PROTO    = 17'd23;
  localparam logic [CountW-1:0] POS_SRC_FIRST = 17'd26;
  localparam logic [CountW-1:0] POS_SRC_LAST  = 17'd29;
  localparam logic [CountW-1:0] POS_DST_FIRST = 17'd30;
  localparam logic [CountW-1:0] POS_DST_LAST  = 17'd33;
  localparam logic [CountW-1:0] POS_SPORT_HI = 17'd34;
  localparam logic [CountW-1:0] POS_SPORT_LO = 17'd35;
  localparam logic [CountW-1:0] POS_DPORT_HI = 17'd36;
  localparam logic [CountW-1:0] POS_DPORT_LO = 17'd37;
  localparam logic [CountW-1:0] POS_ULEN_HI  = 17'd38;
  localparam logic [CountW-1:0] POS_ULEN_LO  = 17'd39;
  localparam logic [CountW-1:0] POS_TOFF_HI  = 17'd46;
  localparam logic [CountW-1:0] POS_TOFF_LO  = 17'd47;

  // minimum frame lengths
  localparam logic [CountW-1:0] MIN_LEN_IP  = 17'd34;
  localparam logic [CountW-1:0] MIN_LEN_UDP = 17'd42;
  localparam logic [CountW-1:0] MIN_LEN_TCP = 17'd54;
  localparam logic [CountW:0]   ETH_HDR_LEN = 18'd14;

  // header constants
  localparam logic [15:0] ETYPE_IPV4   = 16'h0800;
  localparam logic [7:0]  VER_IHL_NOPT = 8'h45;
  localparam logic [15:0] FRAG_MASK    = 16'h3FFF;
  localparam logic [7:0]  PROTO_TCP    = 8'd6;
  localparam logic [7:0]  PROTO_UDP    = 8'd17;
  localparam logic [15:0] IP_HDR_LEN   = 16'd20;
  localparam logic [15:0] IP_MIN_UDP   = 16'd28;
  localparam logic [15:0] IP_MIN_TCP   = 16'd40;
  localparam logic [5:0]  TCP_MIN_HDR  = 6'd20;
  localparam logic [15:0] UDP_MIN_LEN  = 16'd8;

  // source address filters
  localparam logic [31:0] ADDR_BCAST  = 32'hFFFFFFFF;
  localparam logic [31:0] MCAST_MASK  = 32'hF0000000;
  localparam logic [31:0] MCAST_NET   = 32'hE0000000;
  localparam logic [31:0] LOOP_MASK   = 32'hFF000000;
  localparam logic [31:0] LOOP_NET    = 32'h7F000000;

  // verdict queue
  localparam int unsigned QDepth = 2;
  localparam int unsigned QPtrW  = 1;
  localparam int unsigned QCntW  = 2;

  // captured header of one finished frame
  typedef struct packed {
    logic [CountW-1:0] frame_len;
    logic [15:0]       ether_type;
    logic [7:0]        version_ihl;
    logic [15:0]       fragment_word;
    logic [15:0]       total_length;
    logic [7:0]        time_to_live;
    logic [7:0]        proto_byte;
    logic [31:0]       src_capture;
    logic [31:0]       dst_capture;
    logic [15:0]       sport_capture;
    logic [15:0]       dport_capture;
    logic [15:0]       l4_length_word;
  } frame_rec_t;

  // push side of the verdict queue
  typedef struct packed {
    logic       valid;
    frame_rec_t rec;
  } rec_push_t;

endpackage
`default_nettype wire

@@ rtl/iffp_in_if.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// iffp_in_if: frame byte channel
// One beat carries one frame byte and its last marker.
// ----------------------------------------------------------------------------
interface iffp_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] frame_byte;
  logic       frame_last;

  modport source (output valid, output frame_byte, output frame_last, input ready);
  modport sink   (input valid, input frame_byte, input frame_last, output ready);
endinterface
`default_nettype wire

@@ rtl/iffp_out_if.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// iffp_out_if: verdict channel
// One beat carries the verdict and flow key of one frame.
// ----------------------------------------------------------------------------
interface iffp_out_if;
  logic        valid;
  logic        ready;
  logic        accepted;
  logic [31:0] src_address;
  logic [31:0] dst_address;
  logic [15:0] l4_sport;
  logic [15:0] l4_dport;
  logic [7:0]  protocol;

  modport source (output valid, output accepted, output src_address, output dst_address,
                  output l4_sport, output l4_dport, output protocol, input ready);
  modport sink   (input valid, input accepted, input src_address, input dst_address,
                  input l4_sport, input l4_dport, input protocol, output ready);
endinterface
`default_nettype wire

@@ rtl/iffp_front.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// iffp_front: byte counter and header capture
// Counts frame bytes, shifts header fields into place and pushes the
// captured header into the verdict queue on the last byte.
// ----------------------------------------------------------------------------
module iffp_front (
  input  wire                  clk,
  input  wire                  rst_n,
  iffp_in_if.sink              in_chan,
  input  wire                  push_ready,
  output iffp_pkg::rec_push_t  push
);

  logic [iffp_pkg::CountW-1:0] byte_count_r, byte_count_nxt;
  logic [15:0] ether_type_r, ether_type_nxt;
  logic [7:0]  version_ihl_r, version_ihl_nxt;
  logic [15:0] fragment_word_r, fragment_word_nxt;
  logic [15:0] total_length_r, total_length_nxt;
  logic [7:0]  time_to_live_r, time_to_live_nxt;
  logic [7:0]  proto_byte_r, proto_byte_nxt;
  logic [31:0] src_capture_r, src_capture_nxt;
  logic [31:0] dst_capture_r, dst_capture_nxt;
  logic [15:0] sport_capture_r, sport_capture_nxt;
  logic [15:0] dport_capture_r, dport_capture_nxt;
  logic [15:0] l4_length_word_r, l4_length_word_nxt;

  logic                        beat;
  logic [iffp_pkg::CountW-1:0] pos;
  logic [iffp_pkg::CountW-1:0] frame_len;
  logic [7:0]                  b;
  iffp_pkg::frame_rec_t        cap;

  assign in_chan.ready = push_ready;
  assign beat          = in_chan.valid && push_ready;
  assign pos           = byte_count_r;
  assign b             = in_chan.frame_byte;
  assign frame_len     = (pos != iffp_pkg::COUNT_MAX) ? pos + 1'b1 : iffp_pkg::COUNT_MAX;

  // field capture for the current byte position
  always_comb begin
    cap                = '0;
    cap.frame_len      = frame_len;
    cap.ether_type     = ether_type_r;
    cap.version_ihl    = version_ihl_r;
    cap.fragment_word  = fragment_word_r;
    cap.total_length   = total_length_r;
    cap.time_to_live   = time_to_live_r;
    cap.proto_byte     = proto_byte_r;
    cap.src_capture    = src_capture_r;
    cap.dst_capture    = dst_capture_r;
    cap.sport_capture  = sport_capture_r;
    cap.dport_capture  = dport_capture_r;
    cap.l4_length_word = l4_length_word_r;
    if (pos == iffp_pkg::POS_ETYPE_HI || pos == iffp_pkg::POS_ETYPE_LO) begin
      cap.ether_type = {ether_type_r[7:0], b};
    end else if (pos == iffp_pkg::POS_VER_IHL) begin
      cap.version_ihl = b;
    end else if (pos == iffp_pkg::POS_TLEN_HI || pos == iffp_pkg::POS_TLEN_LO) begin
      cap.total_length = {total_length_r[7:0], b};
    end else if (pos == iffp_pkg::POS_FRAG_HI || pos == iffp_pkg::POS_FRAG_LO) begin
      cap.fragment_word = {fragment_word_r[7:0], b};
    end else if (pos == iffp_pkg::POS_TTL) begin
      cap.time_to_live = b;
    end else if (pos == iffp_pkg::POS_PROTO) begin
      cap.proto_byte = b;
    end else if (pos >= iffp_pkg::POS_SRC_FIRST && pos <= iffp_pkg::POS_SRC_LAST) begin
      cap.src_capture = {src_capture_r[23:0], b};
    end else if (pos >= iffp_pkg::POS_DST_FIRST && pos <= iffp_pkg::POS_DST_LAST) begin
      cap.dst_capture = {dst_capture_r[23:0], b};
    end else if (pos == iffp_pkg::POS_SPORT_HI || pos == iffp_pkg::POS_SPORT_LO) begin
      cap.sport_capture = {sport_capture_r[7:0], b};
    end else if (pos == iffp_pkg::POS_DPORT_HI || pos == iffp_pkg::POS_DPORT_LO) begin
      cap.dport_capture = {dport_capture_r[7:0], b};
    end else if (proto_byte_r == iffp_pkg::PROTO_UDP &&
                 (pos == iffp_pkg::POS_ULEN_HI || pos == iffp_pkg::POS_ULEN_LO)) begin
      cap.l4_length_word = {l4_length_word_r[7:0], b};
    end else if (proto_byte_r != iffp_pkg::PROTO_UDP &&
                 (pos == iffp_pkg::POS_TOFF_HI || pos == iffp_pkg::POS_TOFF_LO)) begin
      cap.l4_length_word = {l4_length_word_r[7:0], b};
    end
  end

  // next state: advance on a beat, clear after the last one
  always_comb begin
    byte_count_nxt     = byte_count_r;
    ether_type_nxt     = ether_type_r;
    version_ihl_nxt    = version_ihl_r;
    fragment_word_nxt  = fragment_word_r;
    total_length_nxt   = total_length_r;
    time_to_live_nxt   = time_to_live_r;
    proto_byte_nxt     = proto_byte_r;
    src_capture_nxt    = src_capture_r;
    dst_capture_nxt    = dst_capture_r;
    sport_capture_nxt  = sport_capture_r;
    dport_capture_nxt  = dport_capture_r;
    l4_length_word_nxt = l4_length_word_r;
    if (beat && in_chan.frame_last) begin
      byte_count_nxt     = '0;
      ether_type_nxt     = '0;
      version_ihl_nxt    = '0;
      fragment_word_nxt  = '0;
      total_length_nxt   = '0;
      time_to_live_nxt   = '0;
      proto_byte_nxt     = '0;
      src_capture_nxt    = '0;
      dst_capture_nxt    = '0;
      sport_capture_nxt  = '0;
      dport_capture_nxt  = '0;
      l4_length_word_nxt = '0;
    end else if (beat) begin
      byte_count_nxt     = frame_len;
      ether_type_nxt     = cap.ether_type;
      version_ihl_nxt    = cap.version_ihl;
      fragment_word_nxt  = cap.fragment_word;
      total_length_nxt   = cap.total_length;
      time_to_live_nxt   = cap.time_to_live;
      proto_byte_nxt     = cap.proto_byte;
      src_capture_nxt    = cap.src_capture;
      dst_capture_nxt    = cap.dst_capture;
      sport_capture_nxt  = cap.sport_capture;
      dport_capture_nxt  = cap.dport_capture;
      l4_length_word_nxt = cap.l4_length_word;
    end
  end

  // state registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      byte_count_r     <= '0;
      ether_type_r     <= '0;
      version_ihl_r    <= '0;
      fragment_word_r  <= '0;
      total_length_r   <= '0;
      time_to_live_r   <= '0;
      proto_byte_r     <= '0;
      src_capture_r    <= '0;
      dst_capture_r    <= '0;
      sport_capture_r  <= '0;
      dport_capture_r  <= '0;
      l4_length_word_r <= '0;
    end else begin
      byte_count_r     <= byte_count_nxt;
      ether_type_r     <= ether_type_nxt;
      version_ihl_r    <= version_ihl_nxt;
      fragment_word_r  <= fragment_word_nxt;
      total_length_r   <= total_length_nxt;
      time_to_live_r   <= time_to_live_nxt;
      proto_byte_r     <= proto_byte_nxt;
      src_capture_r    <= src_capture_nxt;
      dst_capture_r    <= dst_capture_nxt;
      sport_capture_r  <= sport_capture_nxt;
      dport_capture_r  <= dport_capture_nxt;
      l4_length_word_r <= l4_length_word_nxt;
    end
  end

  // header record goes to the queue with the last byte
  assign push.valid = beat && in_chan.frame_last;
  assign push.rec   = cap;

`ifndef SYNTH
  // a last beat starts the next frame from an empty counter
  a_count_clears: assert property (@(posedge clk) disable iff (!rst_n)
    (in_chan.valid && in_chan.ready && in_chan.frame_last) |=> (byte_count_r == '0))
    else $error("byte counter not cleared after last beat");

  // the counter sticks at its ceiling
  a_count_saturates: assert property (@(posedge clk) disable iff (!rst_n)
    (byte_count_r == iffp_pkg::COUNT_MAX && !(in_chan.valid && in_chan.ready &&
     in_chan.frame_last)) |=> (byte_count_r == iffp_pkg::COUNT_MAX))
    else $error("byte counter wrapped");
`endif

endmodule
`default_nettype wire

@@ rtl/iffp_queue.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// iffp_queue: header record queue
// Short register queue between capture and verdict so that each side
// stalls on its own.
// ----------------------------------------------------------------------------
module iffp_queue (
  input  wire                   clk,
  input  wire                   rst_n,
  input  iffp_pkg::rec_push_t   push,
  output logic                  push_ready,
  output logic                  pop_valid,
  output iffp_pkg::frame_rec_t  pop_rec,
  input  wire                   pop_ready
);

  iffp_pkg::frame_rec_t          entry_r [iffp_pkg::QDepth];
  logic [iffp_pkg::QPtrW-1:0]    wr_ptr_r, wr_ptr_nxt;
  logic [iffp_pkg::QPtrW-1:0]    rd_ptr_r, rd_ptr_nxt;
  logic [iffp_pkg::QCntW-1:0]    count_r, count_nxt;
  logic                          do_push;
  logic                          do_pop;

  assign push_ready = (count_r != iffp_pkg::QCntW'(iffp_pkg::QDepth));
  assign pop_valid  = (count_r != '0);
  assign pop_rec    = entry_r[rd_ptr_r];
  assign do_push    = push.valid && push_ready;
  assign do_pop     = pop_valid && pop_ready;

  // pointers and fill level
  always_comb begin
    wr_ptr_nxt = do_push ? wr_ptr_r + 1'b1 : wr_ptr_r;
    rd_ptr_nxt = do_pop  ? rd_ptr_r + 1'b1 : rd_ptr_r;
    count_nxt  = count_r;
    if (do_push && !do_pop) begin
      count_nxt = count_r + 1'b1;
    end else if (do_pop && !do_push) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  // record storage
  always_ff @(posedge clk) begin
    if (do_push) begin
      entry_r[wr_ptr_r] <= push.rec;
    end
  end

`ifndef SYNTH
  // fill level and pointers agree
  a_fill_matches_ptrs: assert property (@(posedge clk) disable iff (!rst_n)
    (count_r == '0 || count_r == iffp_pkg::QCntW'(iffp_pkg::QDepth)) |->
    (wr_ptr_r == rd_ptr_r))
    else $error("queue pointers disagree with fill level");
`endif

endmodule
`default_nettype wire

@@ rtl/iffp_back.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// iffp_back: frame verdict and result register
// Checks one captured header per cycle when the output register can load, and
// holds the verdict and flow key in that register until it is taken.
// ----------------------------------------------------------------------------
module iffp_back (
  input  wire                   clk,
  input  wire                   rst_n,
  input  wire                   rec_valid,
  input  iffp_pkg::frame_rec_t  rec,
  output logic                  rec_ready,
  iffp_out_if.source            out_chan
);

  logic        out_valid_r, out_valid_nxt;
  logic        accepted_r;
  logic [31:0] src_address_r;
  logic [31:0] dst_address_r;
  logic [15:0] l4_sport_r;
  logic [15:0] l4_dport_r;
  logic [7:0]  protocol_r;

  logic        ok;
  logic        ip_ok;
  logic        src_ok;
  logic [5:0]  tcp_hdr_len;
  logic        load;

  assign tcp_hdr_len = {rec.l4_length_word[15:12], 2'b00};

  // network layer and source checks
  always_comb begin
    ip_ok = (rec.frame_len >= iffp_pkg::MIN_LEN_IP) &&
            (rec.ether_type == iffp_pkg::ETYPE_IPV4) &&
            (rec.version_ihl == iffp_pkg::VER_IHL_NOPT) &&
            ((rec.fragment_word & iffp_pkg::FRAG_MASK) == '0) &&
            (rec.total_length >= iffp_pkg::IP_HDR_LEN) &&
            (({2'b00, rec.total_length} + iffp_pkg::ETH_HDR_LEN) <=
             {1'b0, rec.frame_len}) &&
            (rec.time_to_live != '0);
    src_ok = (rec.src_capture != '0) &&
             (rec.src_capture != iffp_pkg::ADDR_BCAST) &&
             ((rec.src_capture & iffp_pkg::MCAST_MASK) != iffp_pkg::MCAST_NET) &&
             ((rec.src_capture & iffp_pkg::LOOP_MASK) != iffp_pkg::LOOP_NET);
  end

  // transport layer checks
  always_comb begin
    ok = 1'b0;
    if (ip_ok && src_ok) begin
      if (rec.proto_byte == iffp_pkg::PROTO_TCP) begin
        ok = (rec.total_length >= iffp_pkg::IP_MIN_TCP) &&
             (rec.frame_len >= iffp_pkg::MIN_LEN_TCP) &&
             (tcp_hdr_len >= iffp_pkg::TCP_MIN_HDR) &&
             (({11'd0, tcp_hdr_len} + {1'b0, iffp_pkg::IP_HDR_LEN}) <=
              {1'b0, rec.total_length});
      end else if (rec.proto_byte == iffp_pkg::PROTO_UDP) begin
        ok = (rec.total_length >= iffp_pkg::IP_MIN_UDP) &&
             (rec.frame_len >= iffp_pkg::MIN_LEN_UDP) &&
             (rec.l4_length_word >= iffp_pkg::UDP_MIN_LEN) &&
             (({1'b0, rec.l4_length_word} + {1'b0, iffp_pkg::IP_HDR_LEN}) <=
              {1'b0, rec.total_length});
      end
    end
  end

  // output register handshake
  assign rec_ready = !out_valid_r || out_chan.ready;
  assign load      = rec_valid && rec_ready;

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (load) begin
      out_valid_nxt = 1'b1;
    end else if (out_chan.ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  // result payload, zeroed on rejection
  always_ff @(posedge clk) begin
    if (load) begin
      accepted_r    <= ok;
      src_address_r <= ok ? rec.src_capture   : '0;
      dst_address_r <= ok ? rec.dst_capture   : '0;
      l4_sport_r    <= ok ? rec.sport_capture : '0;
      l4_dport_r    <= ok ? rec.dport_capture : '0;
      protocol_r    <= ok ? rec.proto_byte    : '0;
    end
  end

  assign out_chan.valid       = out_valid_r;
  assign out_chan.accepted    = accepted_r;
  assign out_chan.src_address = src_address_r;
  assign out_chan.dst_address = dst_address_r;
  assign out_chan.l4_sport    = l4_sport_r;
  assign out_chan.l4_dport    = l4_dport_r;
  assign out_chan.protocol    = protocol_r;

`ifndef SYNTH
  // a rejected frame carries an all-zero key
  a_reject_zero_key: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && !accepted_r) |->
    (src_address_r == '0 && dst_address_r == '0 && l4_sport_r == '0 &&
     l4_dport_r == '0 && protocol_r == '0))
    else $error("rejected verdict with nonzero key");

  // an accepted frame is always tcp or udp
  a_accept_proto: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && accepted_r) |->
    (protocol_r == iffp_pkg::PROTO_TCP || protocol_r == iffp_pkg::PROTO_UDP))
    else $error("accepted verdict with foreign protocol");
`endif

endmodule
`default_nettype wire

@@ rtl/ipv4_flow_header_parser.sv @@
`default_nettype none
// A verdict passes the header queue and the output register after its last byte.
// Throughput: one byte per cycle unless stalled; verdicts at up to one per cycle.
// The two-entry header queue plus the output register absorb output stalls;
// input ready drops only while the queue is full.
// Reset (synchronous, active low) clears the byte counter, all captured
// fields, the queue and the output valid.
// ----------------------------------------------------------------------------
// ipv4_flow_header_parser: Ethernet / IPv4 / TCP-UDP flow header parser
// Byte-wide capture front end, header queue and verdict back end.
// ----------------------------------------------------------------------------
module ipv4_flow_header_parser (
  input  wire         clk,
  input  wire         rst_n,
  iffp_in_if.sink     in_chan,
  iffp_out_if.source  out_chan
);

  iffp_pkg::rec_push_t   push;
  logic                  push_ready;
  logic                  q_valid;
  iffp_pkg::frame_rec_t  q_rec;
  logic                  q_ready;

  // capture front end
  iffp_front u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_chan    (in_chan),
    .push_ready (push_ready),
    .push       (push)
  );

  // header record queue
  iffp_queue u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (push),
    .push_ready (push_ready),
    .pop_valid  (q_valid),
    .pop_rec    (q_rec),
    .pop_ready  (q_ready)
  );

  // verdict back end
  iffp_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .rec_valid (q_valid),
    .rec       (q_rec),
    .rec_ready (q_ready),
    .out_chan  (out_chan)
  );

endmodule
`default_nettype wire

@@ dv/flow_verdict_checker.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// flow_verdict_checker: predictor and scoreboard for the flow header parser
// Follows every frame byte taken by the parser, rebuilds the captured
// header and queues the verdict due at the last byte. Each verdict beat
// from the parser is checked field by field against the oldest entry.
// ----------------------------------------------------------------------------
module flow_verdict_checker (
  input  wire  clk,
  input  wire  rst_n,
  iffp_in_if   in_chan,
  iffp_out_if  out_chan,
  output int   mismatch_count,
  output int   verdicts_pending,
  output int   verdicts_seen,
  output int   flows_accepted
);

  typedef struct packed {
    logic        accepted;
    logic [31:0] src_address;
    logic [31:0] dst_address;
    logic [15:0] l4_sport;
    logic [15:0] l4_dport;
    logic [7:0]  protocol;
  } flow_verdict_t;

  flow_verdict_t expected_verdicts[$];

  // header fields of the frame in flight
  logic [iffp_pkg::CountW-1:0] bytes_in_frame;
  logic [15:0]       hdr_etype;
  logic [7:0]        hdr_ver_ihl;
  logic [15:0]       hdr_tlen;
  logic [15:0]       hdr_frag;
  logic [7:0]        hdr_ttl;
  logic [7:0]        hdr_proto;
  logic [31:0]       hdr_src;
  logic [31:0]       hdr_dst;
  logic [15:0]       hdr_sport;
  logic [15:0]       hdr_dport;
  logic [15:0]       hdr_l4word;

  task automatic clear_header();
    bytes_in_frame = '0;
    hdr_etype      = '0;
    hdr_ver_ihl    = '0;
    hdr_tlen       = '0;
    hdr_frag       = '0;
    hdr_ttl        = '0;
    hdr_proto      = '0;
    hdr_src        = '0;
    hdr_dst        = '0;
    hdr_sport      = '0;
    hdr_dport      = '0;
    hdr_l4word     = '0;
  endtask

  task automatic report_mismatch(input string why, input flow_verdict_t got,
                                 input bit has_want, input flow_verdict_t want);
    mismatch_count++;
    if (mismatch_count <= 10) begin
      $display("[%0t] %s", $time, why);
      $display("  got  acc=%0b src=%h dst=%h sport=%h dport=%h proto=%0d",
               got.accepted, got.src_address, got.dst_address,
               got.l4_sport, got.l4_dport, got.protocol);
      if (has_want)
        $display("  want acc=%0b src=%h dst=%h sport=%h dport=%h proto=%0d",
                 want.accepted, want.src_address, want.dst_address,
                 want.l4_sport, want.l4_dport, want.protocol);
    end
  endtask

  always @(posedge clk) begin : predict_and_compare
    flow_verdict_t     got;
    flow_verdict_t     want;
    logic [iffp_pkg::CountW-1:0] pos;
    logic [7:0]        b;
    int unsigned       n;
    int unsigned       ip_len;
    int unsigned       doff_bytes;
    int unsigned       udp_len;
    bit                ip_ok;
    bit                l4_ok;

    if (!rst_n) begin
      clear_header();
      expected_verdicts.delete();
    end else begin
      // verdict beat leaving the parser
      if (out_chan.valid && out_chan.ready) begin
        got = '{out_chan.accepted, out_chan.src_address, out_chan.dst_address,
                out_chan.l4_sport, out_chan.l4_dport, out_chan.protocol};
        verdicts_seen++;
        if (got.accepted) flows_accepted++;
        if (expected_verdicts.size() == 0) begin
          report_mismatch("verdict with no frame outstanding", got, 1'b0, '0);
        end else begin
          want = expected_verdicts.pop_front();
          if (got.accepted !== want.accepted || got.src_address !== want.src_address ||
              got.dst_address !== want.dst_address || got.l4_sport !== want.l4_sport ||
              got.l4_dport !== want.l4_dport || got.protocol !== want.protocol)
            report_mismatch("verdict mismatch", got, 1'b1, want);
        end
      end

      // frame byte entering the parser
      if (in_chan.valid && in_chan.ready) begin
        b   = in_chan.frame_byte;
        pos = bytes_in_frame;
        n   = (pos != iffp_pkg::COUNT_MAX) ? pos + 1 : iffp_pkg::COUNT_MAX;

        // field capture by byte position
        if (pos == iffp_pkg::POS_ETYPE_HI || pos == iffp_pkg::POS_ETYPE_LO)
          hdr_etype = {hdr_etype[7:0], b};
        else if (pos == iffp_pkg::POS_VER_IHL)
          hdr_ver_ihl = b;
        else if (pos == iffp_pkg::POS_TLEN_HI || pos == iffp_pkg::POS_TLEN_LO)
          hdr_tlen = {hdr_tlen[7:0], b};
        else if (pos == iffp_pkg::POS_FRAG_HI || pos == iffp_pkg::POS_FRAG_LO)
          hdr_frag = {hdr_frag[7:0], b};
        else if (pos == iffp_pkg::POS_TTL)
          hdr_ttl = b;
        else if (pos == iffp_pkg::POS_PROTO)
          hdr_proto = b;
        else if (pos >= iffp_pkg::POS_SRC_FIRST && pos <= iffp_pkg::POS_SRC_LAST)
          hdr_src = {hdr_src[23:0], b};
        else if (pos >= iffp_pkg::POS_DST_FIRST && pos <= iffp_pkg::POS_DST_LAST)
          hdr_dst = {hdr_dst[23:0], b};
        else if (pos == iffp_pkg::POS_SPORT_HI || pos == iffp_pkg::POS_SPORT_LO)
          hdr_sport = {hdr_sport[7:0], b};
        else if (pos == iffp_pkg::POS_DPORT_HI || pos == iffp_pkg::POS_DPORT_LO)
          hdr_dport = {hdr_dport[7:0], b};
        else if (hdr_proto == iffp_pkg::PROTO_UDP &&
                 (pos == iffp_pkg::POS_ULEN_HI || pos == iffp_pkg::POS_ULEN_LO))
          hdr_l4word = {hdr_l4word[7:0], b};
        else if (hdr_proto != iffp_pkg::PROTO_UDP &&
                 (pos == iffp_pkg::POS_TOFF_HI || pos == iffp_pkg::POS_TOFF_LO))
          hdr_l4word = {hdr_l4word[7:0], b};

        if (!in_chan.frame_last) begin
          bytes_in_frame = iffp_pkg::CountW'(n);
        end else begin
          // frame checks; n already saturated with the counter
          ip_len     = hdr_tlen;
          doff_bytes = hdr_l4word[15:12] * 4;
          udp_len    = hdr_l4word;
          ip_ok = n >= iffp_pkg::MIN_LEN_IP && hdr_etype == iffp_pkg::ETYPE_IPV4 &&
                  hdr_ver_ihl == iffp_pkg::VER_IHL_NOPT &&
                  (hdr_frag & iffp_pkg::FRAG_MASK) == '0 &&
                  ip_len >= iffp_pkg::IP_HDR_LEN &&
                  ip_len + iffp_pkg::ETH_HDR_LEN <= n &&
                  hdr_ttl != 8'h00 && hdr_src != '0 && hdr_src != iffp_pkg::ADDR_BCAST &&
                  (hdr_src & iffp_pkg::MCAST_MASK) != iffp_pkg::MCAST_NET &&
                  (hdr_src & iffp_pkg::LOOP_MASK) != iffp_pkg::LOOP_NET;
          case (hdr_proto)
            iffp_pkg::PROTO_TCP: l4_ok = ip_len >= iffp_pkg::IP_MIN_TCP &&
                                         n >= iffp_pkg::MIN_LEN_TCP &&
                                         doff_bytes >= iffp_pkg::TCP_MIN_HDR &&
                                         doff_bytes + iffp_pkg::IP_HDR_LEN <= ip_len;
            iffp_pkg::PROTO_UDP: l4_ok = ip_len >= iffp_pkg::IP_MIN_UDP &&
                                         n >= iffp_pkg::MIN_LEN_UDP &&
                                         udp_len >= iffp_pkg::UDP_MIN_LEN &&
                                         udp_len + iffp_pkg::IP_HDR_LEN <= ip_len;
            default:             l4_ok = 1'b0;
          endcase
          want = '0;
          if (ip_ok && l4_ok)
            want = '{1'b1, hdr_src, hdr_dst, hdr_sport, hdr_dport, hdr_proto};
          expected_verdicts.push_back(want);
          clear_header();
        end
      end
    end
    verdicts_pending = expected_verdicts.size();
  end

endmodule
`default_nettype wire

@@ dv/tb.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// tb: testbench top of the flow header parser
// Sends directed frames for the header checks, a burst of tiny frames
// against a long output hold-off and then random well-formed, damaged and
// noise frames, with bursty input and a patterned output stall. The
// checker predicts and compares every verdict.
// ----------------------------------------------------------------------------
module tb;

  localparam int unsigned LongHold     = 200;
  localparam int unsigned ItemBudget   = 850;
  localparam int unsigned RandomFrames = 3;
  localparam logic [7:0]  PROTO_ICMP   = 8'd1;

  typedef enum int unsigned {RX_STEADY, RX_COIN, RX_SPARSE, RX_PERIODIC} rx_pattern_t;

  logic clk = 1'b0;
  logic rst_n;
  bit   hold_req;

  int          mismatch_count;
  int          verdicts_pending;
  int          verdicts_seen;
  int          flows_accepted;
  int unsigned bytes_sent;
  int unsigned burst_left;
  logic [7:0]  frame_q[$];
  logic [31:0] src_probes[5] = '{32'h00000000, 32'hFFFFFFFF, 32'hE0000001,
                                 32'h7F000001, 32'hF0000001};

  iffp_in_if  in_chan();
  iffp_out_if out_chan();

  ipv4_flow_header_parser u_dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_chan  (in_chan),
    .out_chan (out_chan)
  );

  flow_verdict_checker u_checker (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_chan          (in_chan),
    .out_chan         (out_chan),
    .mismatch_count   (mismatch_count),
    .verdicts_pending (verdicts_pending),
    .verdicts_seen    (verdicts_seen),
    .flows_accepted   (flows_accepted)
  );

  // clock
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  task automatic put16(input int unsigned pos, input logic [15:0] v);
    frame_q[pos]   = v[15:8];
    frame_q[pos+1] = v[7:0];
  endtask

  task automatic put32(input int unsigned pos, input logic [31:0] v);
    put16(pos, v[31:16]);
    put16(pos + 2, v[15:0]);
  endtask

  // well-formed frame of n bytes with random filler, before any damage
  task automatic build_flow(input logic [7:0] proto, input int unsigned ip_len,
                            input int unsigned n, input logic [31:0] src,
                            input logic [31:0] dst, input logic [15:0] sport,
                            input logic [15:0] dport, input logic [15:0] l4word);
    int unsigned span;
    span = (n > 48) ? n : 48;
    frame_q.delete();
    repeat (span) frame_q.push_back(8'($urandom_range(0, 255)));
    put16(iffp_pkg::POS_ETYPE_HI, iffp_pkg::ETYPE_IPV4);
    frame_q[iffp_pkg::POS_VER_IHL] = iffp_pkg::VER_IHL_NOPT;
    put16(iffp_pkg::POS_TLEN_HI, 16'(ip_len));
    put16(iffp_pkg::POS_FRAG_HI, 16'h0000);
    frame_q[iffp_pkg::POS_TTL]   = 8'd64;
    frame_q[iffp_pkg::POS_PROTO] = proto;
    put32(iffp_pkg::POS_SRC_FIRST, src);
    put32(iffp_pkg::POS_DST_FIRST, dst);
    put16(iffp_pkg::POS_SPORT_HI, sport);
    put16(iffp_pkg::POS_DPORT_HI, dport);
    if (proto == iffp_pkg::PROTO_UDP) put16(iffp_pkg::POS_ULEN_HI, l4word);
    else                              put16(iffp_pkg::POS_TOFF_HI, l4word);
    while (frame_q.size() > n) void'(frame_q.pop_back());
  endtask

  task automatic base_udp();
    build_flow(iffp_pkg::PROTO_UDP, 28, 42, 32'h0A000001, 32'hC0A80001, 16'd1234, 16'd53,
               16'd8);
  endtask

  // one beat per byte; bursts with random gaps unless held steady
  task automatic send_frame(input bit steady);
    int unsigned gap;
    foreach (frame_q[i]) begin
      if (burst_left == 0) begin
        burst_left = $urandom_range(1, 40);
        gap = steady ? 0 : $urandom_range(0, 6);
        if (gap != 0) begin
          in_chan.valid <= 1'b0;
          repeat (gap) @(posedge clk);
        end
      end
      burst_left--;
      in_chan.valid      <= 1'b1;
      in_chan.frame_byte <= frame_q[i];
      in_chan.frame_last <= (i == frame_q.size() - 1);
      do @(posedge clk); while (!in_chan.ready);
      bytes_sent++;
    end
  endtask

  task automatic wait_for_verdicts();
    in_chan.valid <= 1'b0;
    @(posedge clk);
    wait (verdicts_pending == 0);
    @(posedge clk);
  endtask

  // verdict receiver: changing stall patterns plus one long hold-off
  initial begin : verdict_sink
    rx_pattern_t pattern;
    int unsigned pattern_left;
    int unsigned hold_left;
    bit          hold_taken;
    pattern      = RX_STEADY;
    pattern_left = 0;
    hold_left    = 0;
    hold_taken   = 1'b0;
    out_chan.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (hold_left != 0) begin
        hold_left--;
        out_chan.ready <= 1'b0;
      end else if (hold_req && !hold_taken) begin
        hold_taken = 1'b1;
        hold_left  = LongHold - 1;
        out_chan.ready <= 1'b0;
      end else begin
        if (pattern_left == 0) begin
          pattern      = rx_pattern_t'($urandom_range(0, 3));
          pattern_left = $urandom_range(16, 160);
        end
        pattern_left--;
        case (pattern)
          RX_STEADY: out_chan.ready <= 1'b1;
          RX_COIN:   out_chan.ready <= 1'($urandom_range(0, 1));
          RX_SPARSE: out_chan.ready <= ($urandom_range(0, 7) != 0);
          default:   out_chan.ready <= pattern_left[2];
        endcase
      end
    end
  end

  initial begin : stimulus
    int unsigned r;
    int unsigned ip_len;
    int unsigned n;
    int unsigned doff;
    int unsigned top8;
    int unsigned cut;
    int unsigned random_frames;
    logic [7:0]  proto;
    logic [15:0] l4word;
    logic [31:0] src;

    in_chan.valid      <= 1'b0;
    in_chan.frame_byte <= 8'h00;
    in_chan.frame_last <= 1'b0;
    rst_n              <= 1'b0;
    hold_req           <= 1'b0;
    burst_left = 0;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;

    // single-byte frame on an empty counter
    frame_q = {8'hFF};
    send_frame(1'b0);

    // smallest legal udp and tcp flows with extreme ports and addresses
    build_flow(iffp_pkg::PROTO_UDP, 28, 42, 32'h0A000001, 32'h00000000, 16'h0000,
               16'hFFFF, 16'd8);
    send_frame(1'b0);
    build_flow(iffp_pkg::PROTO_TCP, 40, 54, 32'hDFFFFFFF, 32'hFFFFFFFF, 16'hFFFF,
               16'h0000, 16'h5018);
    send_frame(1'b0);

    // frame ending one byte before the udp header is complete
    build_flow(iffp_pkg::PROTO_UDP, 28, 41, 32'h0A000001, 32'h0A000002, 16'd1, 16'd2,
               16'd8);
    send_frame(1'b0);

    // vlan tag instead of ipv4, and ip options present
    base_udp();
    put16(iffp_pkg::POS_ETYPE_HI, 16'h8100);
    send_frame(1'b0);
    base_udp();
    frame_q[iffp_pkg::POS_VER_IHL] = 8'h46;
    send_frame(1'b0);

    // more-fragments, then DF with the reserved bit (legal)
    base_udp();
    put16(iffp_pkg::POS_FRAG_HI, 16'h2000);
    send_frame(1'b0);
    base_udp();
    put16(iffp_pkg::POS_FRAG_HI, 16'hC000);
    send_frame(1'b0);

    // expired ttl
    base_udp();
    frame_q[iffp_pkg::POS_TTL] = 8'h00;
    send_frame(1'b0);

    // source filters: zero, broadcast, multicast, loopback, class e
    foreach (src_probes[i]) begin
      build_flow(iffp_pkg::PROTO_UDP, 28, 42, src_probes[i], 32'h0A000009, 16'd7, 16'd9,
                 16'd8);
      send_frame(1'b0);
    end

    // protocol neither tcp nor udp
    base_udp();
    frame_q[iffp_pkg::POS_PROTO] = PROTO_ICMP;
    send_frame(1'b0);

    // total length one past the frame
    base_udp();
    put16(iffp_pkg::POS_TLEN_HI, 16'd29);
    send_frame(1'b0);

    // tcp data offset too small, then larger than the packet
    build_flow(iffp_pkg::PROTO_TCP, 40, 54, 32'h0B000001, 32'h0B000002, 16'd80, 16'd81,
               16'h4010);
    send_frame(1'b0);
    build_flow(iffp_pkg::PROTO_TCP, 40, 54, 32'h0B000001, 32'h0B000002, 16'd80, 16'd81,
               16'h6010);
    send_frame(1'b0);

    // udp length below minimum, then one past the packet
    base_udp();
    put16(iffp_pkg::POS_ULEN_HI, 16'd7);
    send_frame(1'b0);
    build_flow(iffp_pkg::PROTO_UDP, 36, 50, 32'h0C000001, 32'h0C000002, 16'd5, 16'd6,
               16'd17);
    send_frame(1'b0);
    wait_for_verdicts();

    // receiver holds off while tiny frames pile up and stall the input
    hold_req <= 1'b1;
    repeat (12) begin
      frame_q.delete();
      repeat ($urandom_range(1, 4)) frame_q.push_back(8'($urandom_range(0, 255)));
      send_frame(1'b1);
    end
    wait_for_verdicts();

    // random frames: mostly flows with random content, some damaged, some noise
    random_frames = 0;
    while (bytes_sent < ItemBudget || random_frames < RandomFrames) begin
      r = $urandom_range(0, 99);
      if (r < 10) begin
        frame_q.delete();
        repeat ($urandom_range(1, 64)) frame_q.push_back(8'($urandom_range(0, 255)));
      end else begin
        proto = $urandom_range(0, 1) ? iffp_pkg::PROTO_UDP : iffp_pkg::PROTO_TCP;
        if ($urandom_range(0, 19) == 0) proto = 8'($urandom_range(0, 255));
        if (proto == iffp_pkg::PROTO_UDP) begin
          ip_len = 28 + $urandom_range(0, 40);
          case ($urandom_range(0, 7))
            0:       l4word = 16'($urandom_range(0, 65535));
            1:       l4word = 16'(ip_len - 20 - $urandom_range(0, ip_len - 28));
            2:       l4word = 16'(ip_len - 19);
            default: l4word = 16'(ip_len - 20);
          endcase
        end else begin
          doff   = $urandom_range(5, 10);
          ip_len = 20 + doff * 4 + $urandom_range(0, 24);
          l4word = {4'(doff), 12'($urandom_range(0, 4095))};
          if ($urandom_range(0, 5) == 0) l4word[15:12] = 4'($urandom_range(0, 15));
        end
        n = 14 + ip_len + $urandom_range(0, 8);
        if ($urandom_range(0, 7) == 0) n = 14 + ip_len - $urandom_range(1, 4);
        case ($urandom_range(0, 11))
          0:       src = 32'h00000000;
          1:       src = 32'hFFFFFFFF;
          2:       src = {4'hE, 28'($urandom)};
          3:       src = {8'h7F, 24'($urandom)};
          default: begin
            top8 = $urandom_range(1, 223);
            if (top8 == 127) top8 = 126;
            src = {8'(top8), 24'($urandom)};
          end
        endcase
        build_flow(proto, ip_len, n, src, $urandom, 16'($urandom), 16'($urandom), l4word);
        frame_q[iffp_pkg::POS_TTL] = ($urandom_range(0, 15) == 0) ? 8'h00 :
                                     8'($urandom_range(1, 255));
        case ($urandom_range(0, 7))
          0:       put16(iffp_pkg::POS_FRAG_HI, 16'($urandom));
          1, 2:    put16(iffp_pkg::POS_FRAG_HI, 16'h4000);
          default: ;
        endcase
        // occasional damage inside the headers, or a cut-short frame
        if ($urandom_range(0, 5) == 0) begin
          cut = (frame_q.size() > 48) ? 47 : frame_q.size() - 1;
          frame_q[$urandom_range(0, cut)] = 8'($urandom_range(0, 255));
        end
        if ($urandom_range(0, 9) == 0) begin
          cut = $urandom_range(1, frame_q.size());
          while (frame_q.size() > cut) void'(frame_q.pop_back());
        end
      end
      send_frame(1'b0);
      random_frames++;
    end

    wait_for_verdicts();
    repeat (16) @(posedge clk);
    $display("covered %0d frame bytes and %0d verdicts, %0d of them accepted flows;",
             bytes_sent, verdicts_seen, flows_accepted);
    $display("short, damaged, filtered and random frames under output stalls and a hold-off");
    if (verdicts_pending != 0) $display("%0d verdicts never arrived", verdicts_pending);
    if (mismatch_count == 0 && verdicts_pending == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

  // run limit
  initial begin : watchdog
    #40_000_000;
    $display("run limit reached with %0d verdicts outstanding", verdicts_pending);
    $display("== FAIL ==");
    $finish;
  end

endmodule
`default_nettype wire
